FILE: sv/m4au_pkg.sv
// shared types and helpers for the 4x4 fixed-point matrix unit
// used by m4au_ctrl, m4au_dp and matrix4_arith_unit; no dependencies
package m4au_pkg;

    typedef enum logic [3:0] {
        CMD_WR_A     = 4'd0,
        CMD_RD_A     = 4'd1,
        CMD_FILL     = 4'd2,
        CMD_ADD      = 4'd3,
        CMD_SUB      = 4'd4,
        CMD_SCALE    = 4'd5,
        CMD_IDENT    = 4'd6,
        CMD_TRANSP   = 4'd7,
        CMD_WR_B     = 4'd8,
        CMD_WR_VEC   = 4'd9,
        CMD_MUL_A    = 4'd10,
        CMD_PROD_OUT = 4'd11,
        CMD_VEC_PROD = 4'd12
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR,
        ST_RD_ISSUE,
        ST_RD_OUT,
        ST_FILL,
        ST_RMW,
        ST_DOT_ISSUE,
        ST_DOT_WAIT,
        ST_DOT_PUT,
        ST_SWAP
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_WR_A,
        OP_WR_B,
        OP_WR_V,
        OP_TRANSP,
        OP_RD_A,
        OP_RD_OUT,
        OP_FILL,
        OP_IDENT,
        OP_RMW,
        OP_DOT_ISSUE,
        OP_DOT_WR,
        OP_DOT_OUT,
        OP_SWAP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic k_first;
        logic k_last;
        logic rmw_wr;
        logic out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic dot_rdy;
        logic out_busy;
    } t_dp_stat;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_sat_val;

    function automatic t_sat_val f_clip33(input logic [32:0] x);
        t_sat_val r;
        r.sat = (x[32] != x[31]);
        r.val = r.sat ? (x[32] ? 32'h8000_0000 : 32'h7fff_ffff) : x[31:0];
        return r;
    endfunction

    function automatic t_sat_val f_clip48(input logic [47:0] x);
        t_sat_val r;
        r.sat = !((&x[47:31]) || !(|x[47:31]));
        r.val = r.sat ? (x[47] ? 32'h8000_0000 : 32'h7fff_ffff) : x[31:0];
        return r;
    endfunction

endpackage

FILE: sv/m4au_ctrl.sv
// command sequencer for the matrix unit: clear pass, element ops, dot products
// depends on m4au_pkg; drives m4au_dp through t_dp_cmd
module m4au_ctrl #(
    parameter int MATRIX_DIM = 4,
    localparam int CELLS = MATRIX_DIM * MATRIX_DIM,
    localparam int IW = $clog2(MATRIX_DIM),
    localparam int CW = $clog2(CELLS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [3:0]         i_in_cmd,
    output logic               o_in_ready,
    input  m4au_pkg::t_dp_stat i_stat,
    output m4au_pkg::t_dp_cmd  o_cmd,
    output logic [CW-1:0]      o_cnt,
    output logic [IW-1:0]      o_i,
    output logic [IW-1:0]      o_j,
    output logic [IW-1:0]      o_k
);

    localparam logic [IW-1:0] LAST_IDX = IW'(MATRIX_DIM - 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(CELLS - 1);
    localparam logic [CW-1:0] END_CNT  = CW'(CELLS);

    m4au_pkg::t_state r_state, n_state;
    m4au_pkg::t_cmd   r_rcmd, n_rcmd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [IW-1:0]    r_i, n_i, r_j, n_j, r_k, n_k;
    logic             dot_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= m4au_pkg::ST_CLEAR;
            r_rcmd  <= m4au_pkg::CMD_WR_A;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_rcmd  <= n_rcmd;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_rcmd           = r_rcmd;
        n_cnt            = r_cnt;
        n_i              = r_i;
        n_j              = r_j;
        n_k              = r_k;
        o_in_ready       = 1'b0;
        o_cmd.op         = m4au_pkg::OP_NONE;
        o_cmd.k_first    = 1'b0;
        o_cmd.k_last     = 1'b0;
        o_cmd.rmw_wr     = 1'b0;
        o_cmd.out_last   = 1'b0;
        dot_final = (r_rcmd == m4au_pkg::CMD_VEC_PROD) ? (r_i == LAST_IDX)
                                                        : (r_i == LAST_IDX && r_j == LAST_IDX);
        case (r_state)
            m4au_pkg::ST_CLEAR: begin
                o_cmd.op = m4au_pkg::OP_CLEAR;
                n_cnt    = r_cnt + CW'(1);
                if (r_cnt == LAST_CNT) begin
                    n_cnt   = '0;
                    n_state = m4au_pkg::ST_IDLE;
                end
            end
            m4au_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = m4au_pkg::OP_LOAD;
                    n_rcmd   = m4au_pkg::t_cmd'(i_in_cmd);
                    n_cnt    = '0;
                    n_i      = '0;
                    n_j      = '0;
                    n_k      = '0;
                    case (m4au_pkg::t_cmd'(i_in_cmd)) inside
                        m4au_pkg::CMD_WR_A, m4au_pkg::CMD_WR_B, m4au_pkg::CMD_WR_VEC,
                        m4au_pkg::CMD_TRANSP:
                            n_state = m4au_pkg::ST_WR;
                        m4au_pkg::CMD_RD_A:
                            n_state = m4au_pkg::ST_RD_ISSUE;
                        m4au_pkg::CMD_FILL, m4au_pkg::CMD_IDENT:
                            n_state = m4au_pkg::ST_FILL;
                        m4au_pkg::CMD_ADD, m4au_pkg::CMD_SUB, m4au_pkg::CMD_SCALE:
                            n_state = m4au_pkg::ST_RMW;
                        m4au_pkg::CMD_MUL_A, m4au_pkg::CMD_PROD_OUT, m4au_pkg::CMD_VEC_PROD:
                            n_state = m4au_pkg::ST_DOT_ISSUE;
                        default:
                            n_state = m4au_pkg::ST_IDLE;
                    endcase
                end
            end
            m4au_pkg::ST_WR: begin
                case (r_rcmd)
                    m4au_pkg::CMD_WR_A:   o_cmd.op = m4au_pkg::OP_WR_A;
                    m4au_pkg::CMD_WR_B:   o_cmd.op = m4au_pkg::OP_WR_B;
                    m4au_pkg::CMD_WR_VEC: o_cmd.op = m4au_pkg::OP_WR_V;
                    m4au_pkg::CMD_TRANSP: o_cmd.op = m4au_pkg::OP_TRANSP;
                    default:              o_cmd.op = m4au_pkg::OP_NONE;
                endcase
                n_state = m4au_pkg::ST_IDLE;
            end
            m4au_pkg::ST_RD_ISSUE: begin
                o_cmd.op = m4au_pkg::OP_RD_A;
                n_state  = m4au_pkg::ST_RD_OUT;
            end
            m4au_pkg::ST_RD_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = m4au_pkg::OP_RD_OUT;
                    n_state  = m4au_pkg::ST_IDLE;
                end
            end
            m4au_pkg::ST_FILL: begin
                o_cmd.op = (r_rcmd == m4au_pkg::CMD_IDENT) ? m4au_pkg::OP_IDENT
                                                           : m4au_pkg::OP_FILL;
                if (r_j == LAST_IDX) begin
                    n_j = '0;
                    n_i = r_i + IW'(1);
                    if (r_i == LAST_IDX) begin
                        n_state = m4au_pkg::ST_IDLE;
                    end
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            m4au_pkg::ST_RMW: begin
                // read runs one entry ahead of the writeback
                o_cmd.op     = m4au_pkg::OP_RMW;
                o_cmd.rmw_wr = (r_cnt != '0);
                n_cnt        = r_cnt + CW'(1);
                if (r_cnt == END_CNT) begin
                    n_cnt   = '0;
                    n_state = m4au_pkg::ST_IDLE;
                end
            end
            m4au_pkg::ST_DOT_ISSUE: begin
                o_cmd.op      = m4au_pkg::OP_DOT_ISSUE;
                o_cmd.k_first = (r_k == '0);
                o_cmd.k_last  = (r_k == LAST_IDX);
                n_k           = r_k + IW'(1);
                if (r_k == LAST_IDX) begin
                    n_k     = '0;
                    n_state = m4au_pkg::ST_DOT_WAIT;
                end
            end
            m4au_pkg::ST_DOT_WAIT: begin
                if (i_stat.dot_rdy) begin
                    n_state = m4au_pkg::ST_DOT_PUT;
                end
            end
            m4au_pkg::ST_DOT_PUT: begin
                if (r_rcmd == m4au_pkg::CMD_MUL_A || !i_stat.out_busy) begin
                    o_cmd.op       = (r_rcmd == m4au_pkg::CMD_MUL_A) ? m4au_pkg::OP_DOT_WR
                                                                     : m4au_pkg::OP_DOT_OUT;
                    o_cmd.out_last = dot_final;
                    if (r_rcmd == m4au_pkg::CMD_VEC_PROD || r_j == LAST_IDX) begin
                        n_j = '0;
                        n_i = r_i + IW'(1);
                    end else begin
                        n_j = r_j + IW'(1);
                    end
                    if (!dot_final) begin
                        n_state = m4au_pkg::ST_DOT_ISSUE;
                    end else if (r_rcmd == m4au_pkg::CMD_MUL_A) begin
                        n_state = m4au_pkg::ST_SWAP;
                    end else begin
                        n_state = m4au_pkg::ST_IDLE;
                    end
                end
            end
            m4au_pkg::ST_SWAP: begin
                o_cmd.op = m4au_pkg::OP_SWAP;
                n_state  = m4au_pkg::ST_IDLE;
            end
            default: begin
                n_state = m4au_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_cnt = r_cnt;
    assign o_i   = r_i;
    assign o_j   = r_j;
    assign o_k   = r_k;

    a_rdy_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.dot_rdy |-> r_state == m4au_pkg::ST_DOT_WAIT)
        else $error("dot product finished outside the wait state");

    a_rmw_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == m4au_pkg::ST_RMW |-> r_cnt <= END_CNT)
        else $error("element sweep counter ran past the matrix");

endmodule

FILE: sv/m4au_dp.sv
// datapath of the matrix unit: matrix memories, vector, shared mac, output register
// depends on m4au_pkg; sequenced by m4au_ctrl
module m4au_dp #(
    parameter int MATRIX_DIM = 4,
    parameter int FRACTION_BITS = 16,
    localparam int CELLS = MATRIX_DIM * MATRIX_DIM,
    localparam int IW = $clog2(MATRIX_DIM),
    localparam int CW = $clog2(CELLS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  m4au_pkg::t_dp_cmd   i_cmd,
    input  logic [CW-1:0]       i_cnt,
    input  logic [IW-1:0]       i_i,
    input  logic [IW-1:0]       i_j,
    input  logic [IW-1:0]       i_k,
    input  logic [3:0]          i_in_cmd,
    input  logic [1:0]          i_in_row,
    input  logic [1:0]          i_in_col,
    input  logic signed [31:0]  i_in_value,
    input  logic signed [15:0]  i_in_factor,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [31:0]         o_out_value,
    output logic [1:0]          o_out_row,
    output logic [1:0]          o_out_col,
    output logic                o_out_sat,
    output logic                o_out_last,
    output m4au_pkg::t_dp_stat  o_stat
);

    localparam int AW    = $clog2(CELLS);
    localparam int ACC_W = 65 + IW;

    function automatic logic [AW-1:0] f_idx(input int r, input int c);
        int t;
        t = r * MATRIX_DIM + c;
        return AW'(t);
    endfunction

    // two banks addressed as {bank, index}
    logic [31:0] r_a_mem [2**(AW+1)];
    logic [31:0] r_b_mem [CELLS];
    logic [31:0] r_v [MATRIX_DIM];

    m4au_pkg::t_cmd     r_cmd;
    logic [1:0]         r_row, r_col;
    logic signed [31:0] r_value;
    logic signed [15:0] r_factor;
    logic               r_bank, r_tr;

    logic [31:0]        r_am_q, r_bm_q, r_vq;
    logic               r_v1, r_f1, r_l1;
    logic signed [63:0] r_prod;
    logic               r_v2, r_f2, r_l2;
    logic signed [ACC_W-1:0] r_acc;
    logic               r_l3;
    logic [31:0]        r_res;
    logic               r_res_sat;
    logic               r_dot_rdy;

    logic               r_o_valid;
    logic [31:0]        r_o_value;
    logic [1:0]         r_o_row, r_o_col;
    logic               r_o_sat, r_o_last;

    logic               inr;
    logic [AW-1:0]      rc_idx;
    logic [AW:0]        a_raddr, a_waddr;
    logic               a_we;
    logic [31:0]        a_wdata;
    logic signed [31:0] b_op;
    logic signed [47:0] scale_p;
    m4au_pkg::t_sat_val rmw_res;
    logic signed [ACC_W-1:0] q;
    logic               q_sat;
    logic [31:0]        q_val;
    logic [CW-1:0]      wb_cnt;
    logic               out_load;

    assign inr    = (int'(r_row) < MATRIX_DIM) && (int'(r_col) < MATRIX_DIM);
    assign rc_idx = r_tr ? f_idx(int'(r_col), int'(r_row)) : f_idx(int'(r_row), int'(r_col));
    assign wb_cnt = i_cnt - CW'(1);

    // read port of A: row of the dot product, sweep entry, or the addressed element
    always_comb begin
        case (i_cmd.op)
            m4au_pkg::OP_DOT_ISSUE:
                a_raddr = {r_bank, r_tr ? f_idx(int'(i_k), int'(i_i))
                                        : f_idx(int'(i_i), int'(i_k))};
            m4au_pkg::OP_RMW:
                a_raddr = {r_bank, i_cnt[AW-1:0]};
            default:
                a_raddr = {r_bank, rc_idx};
        endcase
    end

    assign scale_p = signed'(r_am_q) * r_factor;

    always_comb begin
        case (r_cmd)
            m4au_pkg::CMD_ADD:
                rmw_res = m4au_pkg::f_clip33({r_am_q[31], r_am_q} + {r_value[31], r_value});
            m4au_pkg::CMD_SUB:
                rmw_res = m4au_pkg::f_clip33({r_am_q[31], r_am_q} - {r_value[31], r_value});
            m4au_pkg::CMD_SCALE:
                rmw_res = m4au_pkg::f_clip48(scale_p);
            default: begin
                rmw_res.sat = 1'b0;
                rmw_res.val = r_am_q;
            end
        endcase
    end

    always_comb begin
        a_we    = 1'b0;
        a_waddr = {r_bank, rc_idx};
        a_wdata = r_value;
        case (i_cmd.op)
            m4au_pkg::OP_CLEAR: begin
                a_we    = 1'b1;
                a_waddr = {1'b0, i_cnt[AW-1:0]};
                a_wdata = '0;
            end
            m4au_pkg::OP_WR_A: begin
                a_we = inr;
            end
            m4au_pkg::OP_FILL: begin
                a_we    = 1'b1;
                a_waddr = {r_bank, f_idx(int'(i_i), int'(i_j))};
            end
            m4au_pkg::OP_IDENT: begin
                // diagonal is the same under either orientation
                a_we    = 1'b1;
                a_waddr = {r_bank, f_idx(int'(i_i), int'(i_j))};
                a_wdata = (i_i == i_j) ? (32'd1 << FRACTION_BITS) : '0;
            end
            m4au_pkg::OP_RMW: begin
                a_we    = i_cmd.rmw_wr;
                a_waddr = {r_bank, wb_cnt[AW-1:0]};
                a_wdata = rmw_res.val;
            end
            m4au_pkg::OP_DOT_WR: begin
                // product goes to the spare bank in plain row order
                a_we    = 1'b1;
                a_waddr = {~r_bank, f_idx(int'(i_i), int'(i_j))};
                a_wdata = r_res;
            end
            default: begin
                a_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_a_mem[a_waddr] <= a_wdata;
        end
        r_am_q <= r_a_mem[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == m4au_pkg::OP_CLEAR) begin
            r_b_mem[i_cnt[AW-1:0]] <= '0;
        end else if (i_cmd.op == m4au_pkg::OP_WR_B && inr) begin
            r_b_mem[f_idx(int'(r_row), int'(r_col))] <= r_value;
        end
        r_bm_q <= r_b_mem[f_idx(int'(i_k), int'(i_j))];
        r_vq   <= r_v[i_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < MATRIX_DIM; n++) begin
                r_v[n] <= '0;
            end
        end else if (i_cmd.op == m4au_pkg::OP_WR_V && int'(r_col) < MATRIX_DIM) begin
            r_v[IW'(r_col)] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == m4au_pkg::OP_LOAD) begin
            r_row    <= i_in_row;
            r_col    <= i_in_col;
            r_value  <= i_in_value;
            r_factor <= i_in_factor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd  <= m4au_pkg::CMD_WR_A;
            r_bank <= 1'b0;
            r_tr   <= 1'b0;
        end else begin
            if (i_cmd.op == m4au_pkg::OP_LOAD) begin
                r_cmd <= m4au_pkg::t_cmd'(i_in_cmd);
            end
            if (i_cmd.op == m4au_pkg::OP_TRANSP) begin
                r_tr <= ~r_tr;
            end
            if (i_cmd.op == m4au_pkg::OP_SWAP) begin
                r_bank <= ~r_bank;
                r_tr   <= 1'b0;
            end
        end
    end

    // mac pipeline: read, multiply, accumulate, shift down and clip
    assign b_op = (r_cmd == m4au_pkg::CMD_VEC_PROD) ? signed'(r_vq) : signed'(r_bm_q);

    always_ff @(posedge i_clk) begin
        r_prod <= signed'(r_am_q) * b_op;
        if (r_v2) begin
            r_acc <= r_f2 ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
        if (r_l3) begin
            r_res     <= q_val;
            r_res_sat <= q_sat;
        end
    end

    assign q     = r_acc >>> FRACTION_BITS;
    assign q_sat = !((&q[ACC_W-1:31]) || !(|q[ACC_W-1:31]));
    assign q_val = q_sat ? (q[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff) : q[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_f1      <= 1'b0;
            r_l1      <= 1'b0;
            r_v2      <= 1'b0;
            r_f2      <= 1'b0;
            r_l2      <= 1'b0;
            r_l3      <= 1'b0;
            r_dot_rdy <= 1'b0;
        end else begin
            r_v1      <= (i_cmd.op == m4au_pkg::OP_DOT_ISSUE);
            r_f1      <= i_cmd.k_first;
            r_l1      <= i_cmd.k_last && (i_cmd.op == m4au_pkg::OP_DOT_ISSUE);
            r_v2      <= r_v1;
            r_f2      <= r_f1;
            r_l2      <= r_l1;
            r_l3      <= r_v2 && r_l2;
            r_dot_rdy <= r_l3;
        end
    end

    assign out_load = (i_cmd.op == m4au_pkg::OP_RD_OUT) || (i_cmd.op == m4au_pkg::OP_DOT_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == m4au_pkg::OP_RD_OUT) begin
            r_o_value <= inr ? r_am_q : '0;
            r_o_row   <= r_row;
            r_o_col   <= r_col;
            r_o_sat   <= 1'b0;
            r_o_last  <= 1'b1;
        end else if (i_cmd.op == m4au_pkg::OP_DOT_OUT) begin
            r_o_value <= r_res;
            r_o_row   <= 2'(i_i);
            r_o_col   <= (r_cmd == m4au_pkg::CMD_VEC_PROD) ? 2'd0 : 2'(i_j);
            r_o_sat   <= r_res_sat;
            r_o_last  <= i_cmd.out_last;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_out_value     = r_o_value;
    assign o_out_row       = r_o_row;
    assign o_out_col       = r_o_col;
    assign o_out_sat       = r_o_sat;
    assign o_out_last      = r_o_last;
    assign o_stat.dot_rdy  = r_dot_rdy;
    assign o_stat.out_busy = r_o_valid && !i_out_ready;

    a_spare_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_we && (a_waddr[AW] != r_bank)) |-> i_cmd.op == m4au_pkg::OP_DOT_WR)
        else $error("write into the spare bank outside product writeback");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_o_valid || i_out_ready))
        else $error("result loaded over one not yet transferred");

endmodule

FILE: sv/matrix4_arith_unit.sv
// Fixed-point matrix unit: keeps working matrix A, operand matrix B and a vector
// (Q16.16 by default) and runs one command per input transfer. After reset the
// unit clears both matrices before it takes a command. Every dot product runs
// through one shared multiply-accumulate fed by one read port of A, and a product
// that goes to the output also waits while the output side stalls. A result
// waits in the output register while the next command is accepted.
module matrix4_arith_unit #(
    parameter int MATRIX_DIM = 4,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // command[3:0], row[5:4], col[7:6], value[39:8], scale_factor[55:40]
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // result_value[31:0], result_row[33:32], result_col[35:34], zero fill above
    output logic [39:0] o_m_axis_tdata,
    // saturated[0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    localparam int CELLS = MATRIX_DIM * MATRIX_DIM;
    localparam int IW = $clog2(MATRIX_DIM);
    localparam int CW = $clog2(CELLS + 1);

    m4au_pkg::t_dp_cmd  dp_cmd;
    m4au_pkg::t_dp_stat dp_stat;
    logic [CW-1:0]      cnt;
    logic [IW-1:0]      ci, cj, ck;
    logic [31:0]        out_value;
    logic [1:0]         out_row, out_col;

    m4au_ctrl #(
        .MATRIX_DIM(MATRIX_DIM)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_cmd   (i_s_axis_tdata[3:0]),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_cnt      (cnt),
        .o_i        (ci),
        .o_j        (cj),
        .o_k        (ck)
    );

    m4au_dp #(
        .MATRIX_DIM   (MATRIX_DIM),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_cnt       (cnt),
        .i_i         (ci),
        .i_j         (cj),
        .i_k         (ck),
        .i_in_cmd    (i_s_axis_tdata[3:0]),
        .i_in_row    (i_s_axis_tdata[5:4]),
        .i_in_col    (i_s_axis_tdata[7:6]),
        .i_in_value  (i_s_axis_tdata[39:8]),
        .i_in_factor (i_s_axis_tdata[55:40]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_value (out_value),
        .o_out_row   (out_row),
        .o_out_col   (out_col),
        .o_out_sat   (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast),
        .o_stat      (dp_stat)
    );

    assign o_m_axis_tdata = {4'b0000, out_col, out_row, out_value};

endmodule

FILE: bench/matrix4_arith_unit_test.sv
// testbench for matrix4_arith_unit: drives matrix commands over the input stream
// and checks every result against an in-bench predictor; depends on m4au_pkg
module matrix4_arith_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  row;
        logic [1:0]  col;
        logic        sat;
        logic        last;
    } t_elem;

    // codes outside the command set
    localparam logic [3:0] CMD_SPARE_LO = 4'd13;
    localparam logic [3:0] CMD_SPARE_HI = 4'd15;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    matrix4_arith_unit uut (.*);

    always #5 i_clk = ~i_clk;

    logic signed [31:0] mat_a [16];
    logic signed [31:0] mat_b [16];
    logic signed [31:0] vec_v [4];
    t_elem              pending_elems [$];
    int                 n_errors = 0;
    int                 n_cmds = 0;
    int                 n_results = 0;
    int                 rx_wait = 0;
    bit                 hold_off = 1'b0;
    bit                 wild_stall = 1'b1;

    function automatic logic [31:0] clip64(input logic signed [63:0] x, output logic s);
        s = (x > 64'sd2147483647) || (x < -64'sd2147483648);
        if (x > 64'sd2147483647) return 32'h7fff_ffff;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    // exact sum, floor shift by 16, then clip
    function automatic logic [31:0] dot_row(input int r, input int c, input bit use_vec,
                                            output logic s);
        logic signed [127:0] acc;
        logic signed [127:0] q;
        acc = 0;
        for (int k = 0; k < 4; k++)
            acc += 128'(mat_a[r*4+k]) * 128'(use_vec ? vec_v[k] : mat_b[k*4+c]);
        q = acc >>> 16;
        s = (q > 128'sd2147483647) || (q < -128'sd2147483648);
        if (q > 128'sd2147483647) return 32'h7fff_ffff;
        if (q < -128'sd2147483648) return 32'h8000_0000;
        return q[31:0];
    endfunction

    task automatic predict_cmd(input logic [3:0] cmd, input logic [1:0] r, input logic [1:0] c,
                               input logic signed [31:0] v, input logic signed [15:0] f);
        logic signed [31:0] tmp [16];
        logic               s;
        t_elem              e;
        case (cmd)
            m4au_pkg::CMD_WR_A: mat_a[r*4+c] = v;
            m4au_pkg::CMD_RD_A: pending_elems.push_back('{mat_a[r*4+c], r, c, 1'b0, 1'b1});
            m4au_pkg::CMD_FILL: for (int i = 0; i < 16; i++) mat_a[i] = v;
            m4au_pkg::CMD_ADD:
                for (int i = 0; i < 16; i++) mat_a[i] = clip64(64'(mat_a[i]) + 64'(v), s);
            m4au_pkg::CMD_SUB:
                for (int i = 0; i < 16; i++) mat_a[i] = clip64(64'(mat_a[i]) - 64'(v), s);
            m4au_pkg::CMD_SCALE:
                for (int i = 0; i < 16; i++) mat_a[i] = clip64(64'(mat_a[i]) * 64'(f), s);
            m4au_pkg::CMD_IDENT:
                for (int i = 0; i < 16; i++) mat_a[i] = (i % 5 == 0) ? 32'h1_0000 : 0;
            m4au_pkg::CMD_TRANSP: begin
                tmp = mat_a;
                for (int i = 0; i < 16; i++) mat_a[i] = tmp[(i % 4)*4 + i/4];
            end
            m4au_pkg::CMD_WR_B: mat_b[r*4+c] = v;
            m4au_pkg::CMD_WR_VEC: vec_v[c] = v;
            m4au_pkg::CMD_MUL_A: begin
                for (int i = 0; i < 16; i++) tmp[i] = dot_row(i/4, i%4, 1'b0, s);
                mat_a = tmp;
            end
            m4au_pkg::CMD_PROD_OUT: for (int i = 0; i < 16; i++) begin
                e.value = dot_row(i/4, i%4, 1'b0, s);
                e.row = 2'(i/4); e.col = 2'(i%4); e.sat = s; e.last = (i == 15);
                pending_elems.push_back(e);
            end
            m4au_pkg::CMD_VEC_PROD: for (int i = 0; i < 4; i++) begin
                e.value = dot_row(i, 0, 1'b1, s);
                e.row = 2'(i); e.col = 2'd0; e.sat = s; e.last = (i == 3);
                pending_elems.push_back(e);
            end
            default: ;
        endcase
    endtask

    // valid stays high after a transfer; it drops at the start of a gap or in release_bus
    task automatic send_cmd(input logic [3:0] cmd, input logic [1:0] r, input logic [1:0] c,
                            input logic [31:0] v, input logic [15:0] f, input bit gaps = 1);
        int gap;
        bit rdy;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {f, v, c, r, cmd};
        // ready depends only on the block state, so it is stable from the falling edge
        do begin
            @(negedge i_clk);
            rdy = o_s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        predict_cmd(cmd, r, c, v, f);
        n_cmds++;
    endtask

    task automatic release_bus();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_elems.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // receiver readiness: a random wait after each transfer while wild_stall is set
    always @(posedge i_clk) begin
        if (hold_off) begin
            i_m_axis_tready <= 1'b0;
        end else if (!wild_stall) begin
            i_m_axis_tready <= 1'b1;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            rx_wait = $urandom_range(0, 7);
            i_m_axis_tready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_m_axis_tready <= (rx_wait == 0);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_elem got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{o_m_axis_tdata[31:0], o_m_axis_tdata[33:32], o_m_axis_tdata[35:34],
                    o_m_axis_tuser, o_m_axis_tlast};
            n_results++;
            if (pending_elems.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
                n_errors++;
            end else begin
                want = pending_elems.pop_front();
                if (got !== want || o_m_axis_tdata[39:36] !== 4'd0) begin
                    $display("%0t: mismatch expected val=%h r=%0d c=%0d sat=%b last=%b",
                             $time, want.value, want.row, want.col, want.sat, want.last);
                    $display("%0t:          actual val=%h r=%0d c=%0d sat=%b last=%b",
                             $time, got.value, got.row, got.col, got.sat, got.last);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_cmd(m4au_pkg::CMD_RD_A, 2'd3, 2'd3, 32'h0, 16'h0);
        send_cmd(m4au_pkg::CMD_WR_A, 2'd0, 2'd0, 32'h7fff_ffff, 16'h0);
        send_cmd(m4au_pkg::CMD_WR_A, 2'd3, 2'd3, 32'h8000_0000, 16'h0);
        send_cmd(m4au_pkg::CMD_RD_A, 2'd0, 2'd0, 32'hffff_ffff, 16'hffff);
        send_cmd(m4au_pkg::CMD_RD_A, 2'd3, 2'd3, 32'h0, 16'h0);
        send_cmd(m4au_pkg::CMD_ADD, 2'd0, 2'd0, 32'h0001_0000, 16'h0);
        send_cmd(m4au_pkg::CMD_SUB, 2'd0, 2'd0, 32'h7fff_ffff, 16'h0);
        send_cmd(m4au_pkg::CMD_SCALE, 2'd0, 2'd0, 32'h0, 16'h8000);
        send_cmd(m4au_pkg::CMD_SCALE, 2'd0, 2'd0, 32'h0, 16'h7fff);
        send_cmd(m4au_pkg::CMD_RD_A, 2'd1, 2'd2, 32'h0, 16'h0);
        send_cmd(m4au_pkg::CMD_FILL, 2'd0, 2'd0, 32'h7fff_ffff, 16'h0);
        send_cmd(m4au_pkg::CMD_WR_B, 2'd3, 2'd3, 32'h7fff_ffff, 16'h0);
        send_cmd(m4au_pkg::CMD_WR_VEC, 2'd0, 2'd3, 32'h8000_0000, 16'h0);
        send_cmd(m4au_pkg::CMD_PROD_OUT, 2'd0, 2'd0, 32'h0, 16'h0);
        send_cmd(m4au_pkg::CMD_VEC_PROD, 2'd0, 2'd0, 32'h0, 16'h0);
        send_cmd(m4au_pkg::CMD_IDENT, 2'd0, 2'd0, 32'h0, 16'h0);
        send_cmd(m4au_pkg::CMD_WR_A, 2'd0, 2'd3, 32'h0003_8000, 16'h0);
        send_cmd(m4au_pkg::CMD_TRANSP, 2'd0, 2'd0, 32'h0, 16'h0);
        send_cmd(m4au_pkg::CMD_RD_A, 2'd3, 2'd0, 32'h0, 16'h0);
        send_cmd(m4au_pkg::CMD_WR_B, 2'd0, 2'd0, 32'hffff_ffff, 16'h0);
        send_cmd(m4au_pkg::CMD_MUL_A, 2'd0, 2'd0, 32'h0, 16'h0);
        send_cmd(m4au_pkg::CMD_RD_A, 2'd0, 2'd0, 32'h0, 16'h0);
        send_cmd(CMD_SPARE_LO, 2'd1, 2'd1, 32'h1234_5678, 16'h0);
        send_cmd(CMD_SPARE_HI, 2'd2, 2'd2, 32'h0, 16'h0);
        send_cmd(m4au_pkg::CMD_PROD_OUT, 2'd0, 2'd0, 32'h0, 16'h0);
        release_bus();
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 16))) - 8 << 16;
        endcase
    endfunction

    task automatic test_random(input int count);
        logic [3:0] cmd;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0)
                cmd = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            else if ($urandom_range(0, 3) == 0)
                cmd = m4au_pkg::CMD_WR_B;
            else
                cmd = 4'($urandom_range(m4au_pkg::CMD_WR_A, m4au_pkg::CMD_VEC_PROD));
            send_cmd(cmd, 2'($urandom()), 2'($urandom()), rand_value(),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 6) - 3));
        end
        release_bus();
    endtask

    // receiver stalls for a long stretch while commands keep coming
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_cmd(m4au_pkg::CMD_PROD_OUT, 2'd0, 2'd0, 32'h0, 16'h0, 0);
                send_cmd(m4au_pkg::CMD_VEC_PROD, 2'd0, 2'd0, 32'h0, 16'h0, 0);
                send_cmd(m4au_pkg::CMD_RD_A, 2'd2, 2'd1, 32'h0, 16'h0, 0);
                send_cmd(m4au_pkg::CMD_PROD_OUT, 2'd0, 2'd0, 32'h0, 16'h0, 0);
                release_bus();
            end
        join
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < 16; i++) begin mat_a[i] = 0; mat_b[i] = 0; end
        for (int i = 0; i < 4; i++) vec_v[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        wait_drained();
        test_random(35);
        wait_drained();
        wild_stall = 1'b0;
        test_random(25);
        wild_stall = 1'b1;
        test_backpressure();
        test_random(30);
        wait_drained();
        $display("ran %0d commands over all opcodes and %0d results,", n_cmds, n_results);
        $display("including saturation, out-of-use codes and long output stalls");
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: sim.f
sv/m4au_pkg.sv
sv/m4au_ctrl.sv
sv/m4au_dp.sv
sv/matrix4_arith_unit.sv
bench/matrix4_arith_unit_test.sv
